>>> rtl/pidd_pkg.sv
// Shared types and constants for the deadband PID core.
// No dependencies; compiled first.
package pidd_pkg;

	localparam int unsigned SAMPLE_SHIFT = 7;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned GAIN_W = 31;
	localparam int unsigned ALPHA_W = 17;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned PROD_W = 64;

	// APB map: 8 registers at 4-byte stride
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	typedef logic signed [DATA_W-1:0] q16_t;
	typedef logic [GAIN_W-1:0] gain_t;
	typedef logic [ALPHA_W-1:0] alpha_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	localparam alpha_t ONE_Q16 = 17'h10000;
	localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
	localparam q16_t Q_MIN = -32'sh7FFF_FFFF - 32'sh1;

	localparam gain_t RST_DEAD_BAND = 31'd131072;
	localparam gain_t RST_INT_BAND = 31'd655360;
	localparam gain_t RST_INT_LIMIT = 31'd655360;
	localparam gain_t RST_OUT_LIMIT = 31'd1310720;
	localparam alpha_t RST_ALPHA = 17'd6554;

	typedef enum logic [2:0] {
		REG_KP = 3'd0,
		REG_KI = 3'd1,
		REG_KD = 3'd2,
		REG_DEAD_BAND = 3'd3,
		REG_INT_BAND = 3'd4,
		REG_INT_LIMIT = 3'd5,
		REG_OUT_LIMIT = 3'd6,
		REG_ALPHA = 3'd7
	} reg_idx_t;

	typedef struct packed {
		gain_t kp;
		gain_t ki;
		gain_t kd;
		gain_t dead_band;
		gain_t integral_band;
		gain_t integral_limit;
		gain_t output_limit;
		alpha_t deriv_alpha;
	} cfg_t;

endpackage

>>> rtl/pidd_if.sv
// Valid/ready channel interfaces for the PID core: sample in, result out.
// Depends on pidd_pkg.
interface pidd_in_if;
	import pidd_pkg::*;

	logic valid;
	logic ready;
	q16_t setpoint;
	q16_t measured;

	modport source (output valid, output setpoint, output measured, input ready);
	modport sink (input valid, input setpoint, input measured, output ready);
endinterface

interface pidd_out_if;
	import pidd_pkg::*;

	logic valid;
	logic ready;
	q16_t control_out;
	q16_t error_used;
	logic out_saturated;
	logic in_dead_band;

	modport source (output valid, output control_out, output error_used,
		output out_saturated, output in_dead_band, input ready);
	modport sink (input valid, input control_out, input error_used,
		input out_saturated, input in_dead_band, output ready);
endinterface

>>> rtl/pid_deadband_filtered_derivative_core.sv
// Positional PID core with dead band, integral separation and filtered derivative.
// Depends on pidd_pkg, pidd_if, pidd_mul and pidd_regs.
//
// One sample beat (setpoint, measured, signed Q16.16) yields one result beat
// (control_out, error_used, out_saturated, in_dead_band). The core handles one
// sample at a time: in_ch.ready is high only while idle. out_ch.valid rises once
// the sequencer reaches its result state, and the core is ready for the next
// sample the cycle after the result beat leaves. The sequencer steps through
// the idle state that takes the sample, the band and integral states for the
// error/band/integral work, then the multiply states, in which five products pass
// through the single shared 32x32 multiplier (filter taps d*alpha and
// D*(1-alpha), then Kp*e, Ki*I, Kd*D, each product registered before it is
// accumulated), then a saturation state and the result state. A stalled result
// beat holds the core in the result state.
// Arithmetic right shifts floor; error and raw derivative are saturated to
// 32 bits; the integral clamps to +/-integral_limit; the output clamps to
// +/-output_limit and out_saturated is set only when strictly beyond it.
// deriv_alpha above 1.0 acts as 1.0. Registers (APB, 4-byte stride): kp, ki,
// kd, dead_band, integral_band, integral_limit, output_limit, deriv_alpha;
// write them only while the core is idle.
module pid_deadband_filtered_derivative_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pidd_pkg::ADDR_W-1:0]     paddr,
	input  logic [pidd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pidd_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	pidd_in_if.sink                         in_ch,
	pidd_out_if.source                      out_ch
);
	import pidd_pkg::*;

	// width of the raw derivative before saturation
	localparam int unsigned DW = DATA_W + 1 + SAMPLE_SHIFT;
	localparam logic signed [DW-1:0] D_MAX = DW'(Q_MAX);
	localparam logic signed [DW-1:0] D_MIN = DW'(Q_MIN);
	localparam prod_t P_MAX = PROD_W'(Q_MAX);
	localparam prod_t P_MIN = PROD_W'(Q_MIN);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BAND,
		ST_INT,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_M5,
		ST_M6,
		ST_SAT,
		ST_OUT
	} state_t;

	cfg_t cfg;

	state_t state_q;
	q16_t e_q;          // error, zeroed in the dead band
	q16_t integ_q;      // integral accumulator
	q16_t prev_q;       // previous error
	q16_t fd_q;         // filtered derivative
	q16_t d_q;          // raw derivative, saturated
	logic int_en_q;
	logic dead_q;
	prod_t acc_q;
	q16_t ctrl_q;
	logic sat_q;

	q16_t mul_a, mul_b;
	prod_t prod;

	pidd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pidd_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// error at accept, saturated to 32 bits
	logic signed [DATA_W:0] diff_w;
	q16_t err_w;
	assign diff_w = {in_ch.setpoint[DATA_W-1], in_ch.setpoint}
		- {in_ch.measured[DATA_W-1], in_ch.measured};
	assign err_w = (diff_w[DATA_W] != diff_w[DATA_W-1])
		? (diff_w[DATA_W] ? Q_MIN : Q_MAX) : diff_w[DATA_W-1:0];

	// band checks on |e|; |MIN| = 2^31 fits unsigned
	logic [DATA_W-1:0] abs_e;
	logic is_dead, in_iband;
	assign abs_e = e_q[DATA_W-1] ? (~e_q + DATA_W'(1)) : e_q;
	assign is_dead = abs_e <= {1'b0, cfg.dead_band};
	assign in_iband = abs_e < {1'b0, cfg.integral_band};

	// integral step, clamped
	logic signed [DATA_W:0] isum, ilim, inlim;
	q16_t inext;
	q16_t e_step;
	assign e_step = e_q >>> SAMPLE_SHIFT;
	assign isum = {integ_q[DATA_W-1], integ_q} + {e_step[DATA_W-1], e_step};
	assign ilim = {2'b00, cfg.integral_limit};
	assign inlim = -ilim;
	always_comb begin
		if (isum > ilim) begin
			inext = ilim[DATA_W-1:0];
		end else if (isum < inlim) begin
			inext = inlim[DATA_W-1:0];
		end else begin
			inext = isum[DATA_W-1:0];
		end
	end

	// raw derivative: (e - prev) * 2^SAMPLE_SHIFT, saturated
	logic signed [DATA_W:0] ediff;
	logic signed [DW-1:0] dsh;
	q16_t dnext;
	assign ediff = {e_q[DATA_W-1], e_q} - {prev_q[DATA_W-1], prev_q};
	assign dsh = DW'(ediff) <<< SAMPLE_SHIFT;
	always_comb begin
		if (dsh > D_MAX) begin
			dnext = Q_MAX;
		end else if (dsh < D_MIN) begin
			dnext = Q_MIN;
		end else begin
			dnext = dsh[DATA_W-1:0];
		end
	end

	// filter coefficient, capped at 1.0
	alpha_t alpha_c, beta_c;
	assign alpha_c = (cfg.deriv_alpha > ONE_Q16) ? ONE_Q16 : cfg.deriv_alpha;
	assign beta_c = ONE_Q16 - alpha_c;

	// filter update from the two tap products
	prod_t fsum, fsh, prod_sh;
	q16_t fnext;
	assign fsum = acc_q + prod;
	assign fsh = fsum >>> FRAC_W;
	assign prod_sh = prod >>> FRAC_W;
	always_comb begin
		if (fsh > P_MAX) begin
			fnext = Q_MAX;
		end else if (fsh < P_MIN) begin
			fnext = Q_MIN;
		end else begin
			fnext = fsh[DATA_W-1:0];
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_M1: begin
				mul_a = d_q;
				mul_b = DATA_W'(alpha_c);
			end
			ST_M2: begin
				mul_a = fd_q;
				mul_b = DATA_W'(beta_c);
			end
			ST_M3: begin
				mul_a = e_q;
				mul_b = DATA_W'(cfg.kp);
			end
			ST_M4: begin
				mul_a = integ_q;
				mul_b = DATA_W'(cfg.ki);
			end
			ST_M5: begin
				mul_a = fd_q;
				mul_b = DATA_W'(cfg.kd);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// output clamp
	prod_t olim, onlim;
	assign olim = PROD_W'(cfg.output_limit);
	assign onlim = -olim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			e_q <= '0;
			integ_q <= '0;
			prev_q <= '0;
			fd_q <= '0;
			d_q <= '0;
			int_en_q <= 1'b0;
			dead_q <= 1'b0;
			acc_q <= '0;
			ctrl_q <= '0;
			sat_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						e_q <= err_w;
						state_q <= ST_BAND;
					end
				end
				ST_BAND: begin
					dead_q <= is_dead;
					int_en_q <= !is_dead && in_iband;
					if (is_dead) begin
						e_q <= '0;
						integ_q <= '0;
					end
					state_q <= ST_INT;
				end
				ST_INT: begin
					if (int_en_q) begin
						integ_q <= inext;
					end
					d_q <= dnext;
					prev_q <= e_q;
					state_q <= ST_M1;
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: begin
					acc_q <= prod;         // d * alpha
					state_q <= ST_M3;
				end
				ST_M3: begin
					fd_q <= fnext;         // + D * (1 - alpha)
					state_q <= ST_M4;
				end
				ST_M4: begin
					acc_q <= prod_sh;      // Kp term
					state_q <= ST_M5;
				end
				ST_M5: begin
					acc_q <= acc_q + prod_sh;  // Ki term
					state_q <= ST_M6;
				end
				ST_M6: begin
					acc_q <= acc_q + prod_sh;  // Kd term
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (acc_q > olim) begin
						ctrl_q <= olim[DATA_W-1:0];
						sat_q <= 1'b1;
					end else if (acc_q < onlim) begin
						ctrl_q <= onlim[DATA_W-1:0];
						sat_q <= 1'b1;
					end else begin
						ctrl_q <= acc_q[DATA_W-1:0];
						sat_q <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.control_out = ctrl_q;
	assign out_ch.error_used = e_q;
	assign out_ch.out_saturated = sat_q;
	assign out_ch.in_dead_band = dead_q;
endmodule

>>> rtl/pidd_mul.sv
// Shared 32x32 signed multiplier with registered product.
// Depends on pidd_pkg.
module pidd_mul (
	input  logic          clk,
	input  pidd_pkg::q16_t a,
	input  pidd_pkg::q16_t b,
	output pidd_pkg::prod_t prod
);
	import pidd_pkg::*;

	prod_t prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;
endmodule

>>> rtl/pidd_regs.sv
// APB configuration registers of the PID core.
// Depends on pidd_pkg.
module pidd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pidd_pkg::ADDR_W-1:0]   paddr,
	input  logic [pidd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pidd_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready,
	output pidd_pkg::cfg_t                cfg
);
	import pidd_pkg::*;

	cfg_t cfg_q;
	reg_idx_t idx;
	logic wr_en;

	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp <= '0;
			cfg_q.ki <= '0;
			cfg_q.kd <= '0;
			cfg_q.dead_band <= RST_DEAD_BAND;
			cfg_q.integral_band <= RST_INT_BAND;
			cfg_q.integral_limit <= RST_INT_LIMIT;
			cfg_q.output_limit <= RST_OUT_LIMIT;
			cfg_q.deriv_alpha <= RST_ALPHA;
		end else if (wr_en) begin
			case (idx)
				REG_KP:        cfg_q.kp <= pwdata[GAIN_W-1:0];
				REG_KI:        cfg_q.ki <= pwdata[GAIN_W-1:0];
				REG_KD:        cfg_q.kd <= pwdata[GAIN_W-1:0];
				REG_DEAD_BAND: cfg_q.dead_band <= pwdata[GAIN_W-1:0];
				REG_INT_BAND:  cfg_q.integral_band <= pwdata[GAIN_W-1:0];
				REG_INT_LIMIT: cfg_q.integral_limit <= pwdata[GAIN_W-1:0];
				REG_OUT_LIMIT: cfg_q.output_limit <= pwdata[GAIN_W-1:0];
				REG_ALPHA:     cfg_q.deriv_alpha <= pwdata[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KP:        prdata = APB_DATA_W'(cfg_q.kp);
			REG_KI:        prdata = APB_DATA_W'(cfg_q.ki);
			REG_KD:        prdata = APB_DATA_W'(cfg_q.kd);
			REG_DEAD_BAND: prdata = APB_DATA_W'(cfg_q.dead_band);
			REG_INT_BAND:  prdata = APB_DATA_W'(cfg_q.integral_band);
			REG_INT_LIMIT: prdata = APB_DATA_W'(cfg_q.integral_limit);
			REG_OUT_LIMIT: prdata = APB_DATA_W'(cfg_q.output_limit);
			REG_ALPHA:     prdata = APB_DATA_W'(cfg_q.deriv_alpha);
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;
endmodule

>>> rtl/pidd_checker.sv
// Port-level checks for the PID core, bound onto the top level.
// Depends on pidd_pkg and pid_deadband_filtered_derivative_core.
module pidd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input pidd_pkg::q16_t control_out,
	input pidd_pkg::q16_t error_used,
	input logic           out_saturated,
	input logic           in_dead_band
);
	import pidd_pkg::*;

	// one sample in flight: ready drops right after a sample beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after a sample beat");

	// never accepting while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("sample accepted while a result is pending");

	// dead band forces a zero error on the result
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_dead_band |-> error_used == '0)
		else $error("error nonzero inside the dead band");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(control_out)
		&& $stable(error_used) && $stable(out_saturated) && $stable(in_dead_band))
		else $error("result changed while stalled");
endmodule

bind pid_deadband_filtered_derivative_core pidd_checker u_pidd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.control_out   (out_ch.control_out),
	.error_used    (out_ch.error_used),
	.out_saturated (out_ch.out_saturated),
	.in_dead_band  (out_ch.in_dead_band)
);

>>> sim/pidd_control_checker.sv
// Scoreboard for the deadband PID core: mirrors APB register writes, predicts one
// result beat per sample beat and compares the result channel field by field.
// Depends on pidd_pkg and pidd_if.
module pidd_control_checker
	import pidd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	pidd_in_if                    in_ch,
	pidd_out_if                   out_ch,
	output int                    fail_count,
	output int                    pending
);

	typedef struct {
		q16_t control_out;
		q16_t error_used;
		logic out_saturated;
		logic in_dead_band;
	} ctrl_result_t;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	cfg_t cfg;
	longint integ_acc;
	longint prev_err;
	longint filt_deriv;
	ctrl_result_t expected_ctrl[$];
	ctrl_result_t exp_r;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// One controller step; updates the mirrored integral, previous error and filter.
	function automatic ctrl_result_t next_control_step(q16_t sp, q16_t ms);
		longint e;
		longint mag;
		longint lim;
		longint d;
		longint a;
		longint sum;
		longint olim;
		ctrl_result_t r;
		e = clamp_to(longint'(sp) - longint'(ms), S32_MIN, S32_MAX);
		mag = (e < 0) ? -e : e;
		r.in_dead_band = 1'b0;
		r.out_saturated = 1'b0;
		if (mag <= longint'(cfg.dead_band)) begin
			e = 0;
			integ_acc = 0;
			r.in_dead_band = 1'b1;
		end else if (mag < longint'(cfg.integral_band)) begin
			lim = longint'(cfg.integral_limit);
			integ_acc = clamp_to(integ_acc + (e >>> SAMPLE_SHIFT), -lim, lim);
		end
		d = clamp_to((e - prev_err) * (longint'(1) << SAMPLE_SHIFT), S32_MIN, S32_MAX);
		a = (cfg.deriv_alpha > ONE_Q16) ? longint'(ONE_Q16) : longint'(cfg.deriv_alpha);
		filt_deriv = clamp_to((d * a + filt_deriv * (longint'(ONE_Q16) - a)) >>> FRAC_W,
			S32_MIN, S32_MAX);
		sum = ((longint'(cfg.kp) * e) >>> FRAC_W)
			+ ((longint'(cfg.ki) * integ_acc) >>> FRAC_W)
			+ ((longint'(cfg.kd) * filt_deriv) >>> FRAC_W);
		olim = longint'(cfg.output_limit);
		if (sum > olim) begin
			sum = olim;
			r.out_saturated = 1'b1;
		end else if (sum < -olim) begin
			sum = -olim;
			r.out_saturated = 1'b1;
		end
		prev_err = e;
		r.control_out = q16_t'(sum);
		r.error_used = q16_t'(e);
		return r;
	endfunction

	function automatic void check_field(string fname, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, fname, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = {31'd0, 31'd0, 31'd0, RST_DEAD_BAND, RST_INT_BAND, RST_INT_LIMIT,
				RST_OUT_LIMIT, RST_ALPHA};
			integ_acc = 0;
			prev_err = 0;
			filt_deriv = 0;
			expected_ctrl.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_KP: cfg.kp = pwdata[GAIN_W-1:0];
					REG_KI: cfg.ki = pwdata[GAIN_W-1:0];
					REG_KD: cfg.kd = pwdata[GAIN_W-1:0];
					REG_DEAD_BAND: cfg.dead_band = pwdata[GAIN_W-1:0];
					REG_INT_BAND: cfg.integral_band = pwdata[GAIN_W-1:0];
					REG_INT_LIMIT: cfg.integral_limit = pwdata[GAIN_W-1:0];
					REG_OUT_LIMIT: cfg.output_limit = pwdata[GAIN_W-1:0];
					REG_ALPHA: cfg.deriv_alpha = pwdata[ALPHA_W-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				expected_ctrl.push_back(next_control_step(in_ch.setpoint, in_ch.measured));
			if (out_ch.valid && out_ch.ready) begin
				if (expected_ctrl.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual %h %h %b %b",
						$time, out_ch.control_out, out_ch.error_used,
						out_ch.out_saturated, out_ch.in_dead_band);
					fail_count++;
				end else begin
					exp_r = expected_ctrl.pop_front();
					check_field("control_out", exp_r.control_out, out_ch.control_out);
					check_field("error_used", exp_r.error_used, out_ch.error_used);
					check_field("out_saturated", exp_r.out_saturated, out_ch.out_saturated);
					check_field("in_dead_band", exp_r.in_dead_band, out_ch.in_dead_band);
				end
			end
			pending = expected_ctrl.size();
		end
	end

endmodule

>>> sim/tb_top.sv
// Top of the deadband PID core testbench: clock, reset, APB register writes,
// sample-beat stimulus and result-side backpressure, plus the final verdict.
// Depends on pidd_pkg, pidd_if, pidd_control_checker and the core.
module tb_top;
	import pidd_pkg::*;

	// No beat for this many cycles means the core is stuck.
	localparam int WATCHDOG_LIMIT = 4000;
	// Margin at the end of the run, after the last result beat.
	localparam int TAIL_CYCLES = 40;
	localparam int SEGMENTS = 8;
	localparam int ITEMS_PER_SEGMENT = 125;

	// Packed order: kp, ki, kd, dead_band, integral_band, integral_limit,
	// output_limit, deriv_alpha.
	localparam cfg_t CFG_MID = {31'd65536, 31'd32768, 31'd655, 31'd131072,
		31'd655360, 31'd655360, 31'd1310720, 17'd6554};
	localparam cfg_t CFG_MAX = {31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
		31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 17'h1_FFFF};
	localparam cfg_t CFG_ZERO = {31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 17'd0};
	// Dead band only at zero error, integral on below full scale with a tiny clamp, unfiltered derivative.
	localparam cfg_t CFG_TIGHT = {31'd196608, 31'd13107200, 31'd65536, 31'd0,
		31'h7FFF_FFFF, 31'd5000, 31'h7FFF_FFFF, 17'd65536};

	typedef enum int {
		IDLE_NONE,
		IDLE_SRC,
		IDLE_SNK,
		IDLE_BOTH
	} idle_phase_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	int fail_count;
	int pending;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;
	cfg_t cur_cfg;

	pidd_in_if in_ch();
	pidd_out_if out_ch();

	pid_deadband_filtered_derivative_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	pidd_control_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result-side backpressure, redrawn every cycle at the falling edge.
	always @(negedge clk) begin
		out_ch.ready <= (stall_pct == 0) || ($urandom_range(99, 0) >= stall_pct);
	end

	// Watchdog: any sample or result beat restarts the count.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	task automatic set_idle(idle_phase_t ph);
		case (ph)
			IDLE_NONE: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			IDLE_SRC: begin
				idle_pct = 75;
				stall_pct = 0;
			end
			IDLE_SNK: begin
				idle_pct = 0;
				stall_pct = 75;
			end
			default: begin
				idle_pct = 32;
				stall_pct = 32;
			end
		endcase
	endtask

	// Setup cycle, access cycle, then one cycle with psel low so that
	// back-to-back writes never lower and raise psel in the same step.
	task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Unused upper data bits carry noise; the core must drop them.
	task automatic apply_cfg(cfg_t c);
		write_reg(REG_KP, {1'($urandom), c.kp});
		write_reg(REG_KI, {1'($urandom), c.ki});
		write_reg(REG_KD, {1'($urandom), c.kd});
		write_reg(REG_DEAD_BAND, {1'($urandom), c.dead_band});
		write_reg(REG_INT_BAND, {1'($urandom), c.integral_band});
		write_reg(REG_INT_LIMIT, {1'($urandom), c.integral_limit});
		write_reg(REG_OUT_LIMIT, {1'($urandom), c.output_limit});
		write_reg(REG_ALPHA, {15'($urandom), c.deriv_alpha});
		cur_cfg = c;
	endtask

	// Called at a falling edge; returns at the falling edge after the beat is
	// taken with valid still high, so the next beat can follow without a gap.
	task automatic send_sample(longint sp, longint ms);
		while ($urandom_range(99, 0) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.setpoint <= q16_t'(sp);
		in_ch.measured <= q16_t'(ms);
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Let every outstanding result beat come back before touching registers.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Wide spread of magnitudes: random bits shifted down by a random amount.
	function automatic logic [30:0] rand_scaled();
		logic [30:0] v;
		v = 31'($urandom);
		return v >> $urandom_range(30, 0);
	endfunction

	function automatic cfg_t rand_cfg();
		cfg_t c;
		c.kp = rand_scaled();
		c.ki = rand_scaled();
		c.kd = rand_scaled();
		c.dead_band = rand_scaled() >> $urandom_range(8, 0);
		c.integral_band = rand_scaled();
		c.integral_limit = rand_scaled();
		c.output_limit = rand_scaled();
		c.deriv_alpha = ($urandom_range(3, 0) == 0) ? 17'($urandom)
			: 17'($urandom_range(65536, 0));
		return c;
	endfunction

	// Mostly errors aimed at the dead band, the integral band and their edges,
	// relative to the current setting; the rest is raw full-range noise.
	task automatic random_item();
		longint ms;
		longint sp;
		longint e;
		longint db;
		longint ib;
		longint span;
		int mode;
		db = longint'(cur_cfg.dead_band);
		ib = longint'(cur_cfg.integral_band);
		mode = $urandom_range(9, 0);
		if ($urandom_range(3, 0) == 0)
			ms = longint'(int'($urandom));
		else
			ms = longint'($urandom_range(32'h0080_0000, 0)) - 64'sh40_0000;
		case (mode)
			0, 1: e = longint'($urandom) % (db + 1);
			2, 3, 4, 5: begin
				span = (ib - db - 1 > 0) ? ib - db - 1 : 1;
				e = db + 1 + longint'($urandom) % span;
			end
			6: begin
				case ($urandom_range(3, 0))
					0: e = db;
					1: e = db + 1;
					2: e = ib - 1;
					default: e = ib;
				endcase
			end
			7: e = ib + longint'(rand_scaled());
			default: e = 0;
		endcase
		if ($urandom_range(1, 0) == 1)
			e = -e;
		if (mode >= 8) begin
			sp = longint'(int'($urandom));
			ms = longint'(int'($urandom));
		end else begin
			sp = ms + e;
			if (sp > 64'sd2147483647)
				sp = 64'sd2147483647;
			if (sp < -64'sd2147483648)
				sp = -64'sd2147483648;
		end
		send_sample(sp, ms);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.setpoint = '0;
		in_ch.measured = '0;
		out_ch.ready = 1'b0;
		quiet_cycles = 0;
		set_idle(IDLE_NONE);
		repeat (3)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: dead band and integral band edges, error saturation both ways.
		apply_cfg(CFG_MID);
		send_sample(0, 0);
		send_sample(131072, 0);
		send_sample(131073, 0);
		send_sample(0, 131072);
		send_sample(0, 131073);
		send_sample(655359, 0);
		send_sample(655360, 0);
		send_sample(0, 655360);
		send_sample(Q_MAX, Q_MIN);
		send_sample(Q_MIN, Q_MAX);
		send_sample(Q_MAX, Q_MAX);
		send_sample(Q_MIN, 0);
		send_sample(32'h0000_8000, 0);

		// Directed: every limit at full scale, alpha beyond one.
		drain_results();
		apply_cfg(CFG_MAX);
		send_sample(Q_MAX, Q_MIN);
		send_sample(Q_MIN, Q_MAX);
		send_sample(1, 0);
		send_sample(Q_MIN, 0);

		// Directed: integral floor on tiny errors and clamp on both sides.
		drain_results();
		apply_cfg(CFG_TIGHT);
		send_sample(0, 0);
		send_sample(1, 0);
		send_sample(-1, 0);
		send_sample(32'h0010_0000, 0);
		send_sample(32'h0010_0000, 0);
		send_sample(-32'sh0010_0000, 0);
		send_sample(-32'sh0010_0000, 0);

		// Directed: all-zero setting, a small error falls outside both bands.
		drain_results();
		apply_cfg(CFG_ZERO);
		send_sample(5, 3);

		// Random segments, each with its own setting and idling mix.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain_results();
			case (seg)
				0: apply_cfg(CFG_MID);
				1: apply_cfg(CFG_TIGHT);
				2: apply_cfg(CFG_MAX);
				5: apply_cfg(CFG_ZERO);
				7: apply_cfg(CFG_MID);
				default: apply_cfg(rand_cfg());
			endcase
			set_idle(idle_phase_t'(seg % 4));
			repeat (ITEMS_PER_SEGMENT)
				random_item();
		end

		drain_results();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
